// ===== design/opsge_pkg.sv =====
// shared types and constants for the order-preserving string group encoder
// no dependencies
package opsge_pkg;

    // widths that the byte fields and the group size range fix
    localparam int BYTE_W = 8;
    // a step count covers up to GROUP_BYTES + 3 results, at most 257
    localparam int STEP_W = 9;

    // what one accepted item has to emit, worked out at acceptance
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte; // string byte passed straight through
        logic              has_end;   // item closes the string
        logic [BYTE_W-1:0] len_byte;  // count of real bytes in the last group
        logic [STEP_W-1:0] mark_at;   // first step of the marker byte
        logic [STEP_W-1:0] zero_at;   // first step of the zero padding
        logic [STEP_W-1:0] len_at;    // step of the length byte
        logic [STEP_W-1:0] total;     // number of results for this item
    } plan_t;

endpackage

// ===== design/order_preserving_string_group_encoder.sv =====
// top level of the order-preserving string group encoder
// depends on opsge_pkg, opsge_plan and opsge_emit
// an item is held in the item register, and each of its results then in the output register
// throughput: one input transfer per cycle while each item gives one result and the output is not stalled
// an item with n results holds the sequencer until all n are emitted (up to GROUP_BYTES + 3)
// reset: synchronous active-low aresetn clears the fill counter and all valid flags
module order_preserving_string_group_encoder
    import opsge_pkg::*;
#(
    parameter int GROUP_BYTES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0]        s_tuser,   // [0] byte_present
    input  logic              s_tlast,   // string_end
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic [0:0]        m_tuser,   // [0] run_last
    output logic              m_tlast    // key_done
);

    logic  accept;
    logic  load;
    logic  take_ok;
    plan_t plan;

    // input transfer; items with nothing to emit are taken without loading the sequencer
    assign s_tready = take_ok;
    assign accept   = s_tvalid && take_ok;
    assign load     = accept && (plan.total != '0);

    // fill counter and the result plan of the item at the port
    opsge_plan #(
        .GROUP_BYTES (GROUP_BYTES)
    ) u_plan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .data_byte    (s_tdata),
        .byte_present (s_tuser[0]),
        .string_end   (s_tlast),
        .plan         (plan)
    );

    // steps through the plan one result per cycle, while the output register is free, into the output register
    opsge_emit #(
        .GROUP_BYTES (GROUP_BYTES)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .plan      (plan),
        .take_ok   (take_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .run_last  (m_tuser[0]),
        .key_done  (m_tlast)
    );

endmodule

// ===== design/opsge_plan.sv =====
// group fill counter and per-item result plan
// depends on opsge_pkg
module opsge_plan
    import opsge_pkg::*;
#(
    parameter int GROUP_BYTES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              byte_present,
    input  logic              string_end,
    output plan_t             plan
);

    localparam int FILL_W = $clog2(GROUP_BYTES);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_after;
    logic              group_full;
    logic [STEP_W-1:0] zero_cnt;

    always_comb begin
        group_full = byte_present && (fill_reg == FILL_W'(GROUP_BYTES - 1));
        if (group_full) begin
            fill_after = '0;
        end else if (byte_present) begin
            fill_after = fill_reg + FILL_W'(1);
        end else begin
            fill_after = fill_reg;
        end

        if (string_end) begin
            zero_cnt = STEP_W'(GROUP_BYTES) - STEP_W'(fill_after);
        end else begin
            zero_cnt = '0;
        end

        plan.data_byte = data_byte;
        plan.has_end   = string_end;
        plan.len_byte  = BYTE_W'(fill_after);
        plan.mark_at   = STEP_W'(byte_present);
        plan.zero_at   = plan.mark_at + STEP_W'(group_full);
        plan.len_at    = plan.zero_at + zero_cnt;
        plan.total     = plan.len_at + STEP_W'(string_end);

        fill_next = string_end ? '0 : fill_after;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== design/opsge_emit.sv =====
// item register, step counter and output register
// depends on opsge_pkg
module opsge_emit
    import opsge_pkg::*;
#(
    parameter int GROUP_BYTES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  plan_t             plan,
    output logic              take_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last,
    output logic              key_done
);

    localparam logic [BYTE_W-1:0] MARK_BYTE = BYTE_W'(GROUP_BYTES + 1);

    logic              item_valid_reg;
    plan_t             plan_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              key_done_reg;

    logic              out_free;
    logic              advance;
    logic              last_step;
    logic [BYTE_W-1:0] byte_next;

    always_comb begin
        out_free  = !out_valid_reg || out_ready;
        advance   = item_valid_reg && out_free;
        last_step = step_reg == (plan_reg.total - STEP_W'(1));
        take_ok   = !item_valid_reg || (advance && last_step);

        if (step_reg < plan_reg.mark_at) begin
            byte_next = plan_reg.data_byte;
        end else if (step_reg < plan_reg.zero_at) begin
            byte_next = MARK_BYTE;
        end else if (step_reg < plan_reg.len_at) begin
            byte_next = '0;
        end else begin
            byte_next = plan_reg.len_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            step_reg       <= '0;
        end else if (load) begin
            item_valid_reg <= 1'b1;
            step_reg       <= '0;
        end else if (advance && last_step) begin
            item_valid_reg <= 1'b0;
        end else if (advance) begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            plan_reg <= plan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg <= byte_next;
            run_last_reg <= last_step;
            key_done_reg <= last_step && plan_reg.has_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign key_done  = key_done_reg;

endmodule

// ===== design/opsge_checker.sv =====
// port-level checks for the order-preserving string group encoder
// bound to order_preserving_string_group_encoder
module opsge_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // the length byte always closes the run of its item
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("key_done without run_last");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind order_preserving_string_group_encoder opsge_checker u_opsge_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench for order_preserving_string_group_encoder: directed and random key strings,
// each result checked against a predictor of the encoded sort-key bytes
// depends on opsge_pkg and the design sources
module tb;
    import opsge_pkg::*;

    localparam int GROUP_BYTES     = 8;
    localparam int FILL_W          = $clog2(GROUP_BYTES);
    // marker byte that follows every full group
    localparam logic [BYTE_W-1:0] GROUP_MARKER = BYTE_W'(GROUP_BYTES + 1);
    // long receiver hold-off, so the block fills up and stalls its input
    localparam int HOLD_OFF_CYCLES = 300;
    // cycles with no transfer on either side before the run is given up
    localparam int WATCHDOG_LIMIT  = 2000;
    // settle time after the last expected result (latency plus a full padding run)
    localparam int SETTLE_CYCLES   = 2 * GROUP_BYTES + 8;

    // one encoded byte as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              key_done;
    } key_byte_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;   // [7:0] data_byte
    logic [0:0]        s_tuser  = '0;   // [0] byte_present
    logic              s_tlast  = 1'b0; // string_end
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;         // [7:0] out_byte
    logic [0:0]        m_tuser;         // [0] run_last
    logic              m_tlast;         // key_done

    // predictor state: data bytes in the open group
    logic [FILL_W-1:0] group_fill = '0;
    // encoded bytes still to come, oldest first
    key_byte_t         key_bytes_q[$];

    int err_count     = 0;
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    order_preserving_string_group_encoder #(
        .GROUP_BYTES(GROUP_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // append one expected byte at the tail of key_bytes_q
    function automatic void queue_key_byte(logic [BYTE_W-1:0] value, logic last,
                                           logic done);
        key_byte_t kb;
        kb = '{out_byte: value, run_last: last, key_done: done};
        key_bytes_q.insert(key_bytes_q.size(), kb);
    endfunction

    // expected encoding of one input transfer, appended to key_bytes_q
    function automatic void predict_key_bytes(logic [BYTE_W-1:0] data, logic present,
                                              logic ending);
        int   k;
        logic full;
        full = present && (group_fill == FILL_W'(GROUP_BYTES - 1));
        // data byte passes straight through, a full group adds the marker
        if (present) begin
            queue_key_byte(data, !full && !ending, 1'b0);
            if (full) begin
                queue_key_byte(GROUP_MARKER, !ending, 1'b0);
                group_fill = '0;
            end else begin
                group_fill = group_fill + 1'b1;
            end
        end
        // end of string: pad the open group with zeros, then the length byte
        if (ending) begin
            for (k = int'(group_fill); k < GROUP_BYTES; k++)
                queue_key_byte('0, 1'b0, 1'b0);
            queue_key_byte(BYTE_W'(group_fill), 1'b1, 1'b1);
            group_fill = '0;
        end
    endfunction

    // input monitor: every accepted transfer feeds the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            predict_key_bytes(s_tdata, s_tuser[0], s_tlast);
    end

    // receiver: random stalls, plus a long hold-off when a test asks for one
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result checker: each output transfer against the oldest expected byte
    always @(posedge aclk) begin
        key_byte_t got;
        key_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.out_byte = m_tdata;
            got.run_last = m_tuser[0];
            got.key_done = m_tlast;
            if (key_bytes_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result: out_byte %02h run_last %b key_done %b",
                         $time, got.out_byte, got.run_last, got.key_done);
            end else begin
                want = key_bytes_q.pop_front();
                if (got !== want) begin
                    err_count++;
                    $display("%0t: mismatch: expected %02h/%b/%b, got %02h/%b/%b",
                             $time, want.out_byte, want.run_last, want.key_done,
                             got.out_byte, got.run_last, got.key_done);
                end
            end
        end
    end

    // watchdog: gives up when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one item, idling at random first, and return once it is accepted
    task automatic send_item(input logic [BYTE_W-1:0] data, input logic present,
                             input logic ending);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= ending;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // sender stays quiet until every expected byte has come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (key_bytes_q.size() != 0)
            @(posedge aclk);
    endtask

    // one well-formed key: random length and content, end merged with the last
    // byte or sent as its own item, with an occasional empty item in between
    task automatic send_random_key(input int max_len, output int sent);
        int len;
        int pick;
        bit merge_end;
        pick = $urandom_range(99);
        if (pick < 10)
            len = 0;
        else if (pick < 85)
            len = $urandom_range(16, 1);
        else
            len = $urandom_range(max_len, 17);
        merge_end = (len > 0) && ($urandom_range(1) == 1);
        sent = 0;
        for (int i = 0; i < len; i++) begin
            // empty item: ignored by the block, not counted
            if ($urandom_range(99) < 4)
                send_item(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
            send_item(BYTE_W'($urandom_range(255)), 1'b1, merge_end && (i == len - 1));
            sent++;
        end
        if (!merge_end) begin
            send_item(BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
            sent++;
        end
    endtask

    // extremes of the fields and special cases of the encoding
    task automatic test_directed();
        logic [BYTE_W-1:0] pattern[8] = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80,
                                          8'h7f, 8'hfe};
        // empty item gives nothing
        send_item(8'ha5, 1'b0, 1'b0);
        // empty string: full zero group and length 0
        send_item(8'h00, 1'b0, 1'b1);
        // one-byte string with the end on the same item
        send_item(8'hff, 1'b1, 1'b1);
        // seven bytes, then a separate end item: one pad byte and length 7
        for (int i = 0; i < 7; i++)
            send_item(pattern[i], 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        // byte that fills the group and ends the string: longest run of results
        for (int i = 0; i < 8; i++)
            send_item(pattern[7 - i], 1'b1, i == 7);
        // short string with an empty item in the middle
        send_item(8'h09, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random_keys(input int n_items, input int src_pct, input int snk_pct);
        int sent;
        int total;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        total = 0;
        while (total < n_items) begin
            send_random_key(40, sent);
            total += sent;
        end
    endtask

    // sender stops mid-run until the block has drained completely
    task automatic test_drain_pause();
        int sent;
        send_random_key(24, sent);
        wait_for_results();
        send_random_key(24, sent);
    endtask

    // receiver holds off while the sender streams a long key back to back
    task automatic test_backpressure();
        int saved_pct;
        saved_pct = src_idle_pct;
        src_idle_pct = 0;
        hold_request = HOLD_OFF_CYCLES;
        for (int i = 0; i < 40; i++)
            send_item(BYTE_W'($urandom_range(255)), 1'b1, i == 39);
        src_idle_pct = saved_pct;
    endtask

    initial begin
        src_idle_pct = 26;
        snk_idle_pct = 45;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_keys(120, 26, 45);
        test_drain_pause();
        test_random_keys(120, 45, 26);
        test_backpressure();
        test_random_keys(120, 0, 0);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0 && key_bytes_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/opsge_pkg.sv
design/opsge_plan.sv
design/opsge_emit.sv
design/order_preserving_string_group_encoder.sv
design/opsge_checker.sv
tb/tb.sv
